/* rtl/stif_pkg.sv */
`timescale 1ns / 1ps

package stif_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 5;
  localparam int STAT_W   = 2;
  localparam int OUT_W    = 16;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_FIND   = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_COMPARE,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic load_op;
    logic capture;
    logic commit;
  } dp_cmd_t;

endpackage

/* rtl/stif_ctrl.sv */
`timescale 1ns / 1ps

module stif_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output stif_pkg::dp_cmd_t cmd
);

  stif_pkg::state_t state;
  stif_pkg::state_t state_next;
  logic             out_free;

  // Output slot can take a new result when empty or being drained now.
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      stif_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = stif_pkg::S_COMPARE;
        end
      end
      stif_pkg::S_COMPARE: begin
        state_next = stif_pkg::S_COMMIT;
      end
      stif_pkg::S_COMMIT: begin
        if (out_free) begin
          state_next = stif_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = stif_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.load_op = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    case (state)
      stif_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_op = in_valid;
      end
      stif_pkg::S_COMPARE: begin
        cmd.capture = 1'b1;
      end
      stif_pkg::S_COMMIT: begin
        cmd.commit = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= stif_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/stif_dp.sv */
`timescale 1ns / 1ps

module stif_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  stif_pkg::dp_cmd_t                    cmd,
  input  logic                                 in_kind,
  input  logic signed [stif_pkg::VALUE_W-1:0]  in_value,
  output logic        [stif_pkg::POS_W-1:0]    res_position,
  output logic        [stif_pkg::STAT_W-1:0]   res_status,
  output logic        [stif_pkg::POS_W-1:0]    res_count
);

  logic                                op_kind;
  logic signed [stif_pkg::VALUE_W-1:0] op_value;
  logic signed [stif_pkg::VALUE_W-1:0] entries [stif_pkg::CAPACITY];
  logic        [stif_pkg::CNT_W-1:0]   count;
  logic        [stif_pkg::CNT_W-1:0]   count_next;
  logic        [stif_pkg::CAPACITY-1:0] lt_mask;
  logic        [stif_pkg::CAPACITY-1:0] eq_mask;
  logic        [stif_pkg::CAPACITY-1:0] lt_now;
  logic        [stif_pkg::CAPACITY-1:0] eq_now;
  logic        [stif_pkg::CAPACITY-1:0] slot_hot;
  logic        [stif_pkg::IDX_W-1:0]   slot_idx;
  logic                                found;
  logic                                full;
  logic                                do_insert;

  // Compare the operand against every held entry at once.
  always_comb begin
    for (int i = 0; i < stif_pkg::CAPACITY; i++) begin
      lt_now[i] = (stif_pkg::CNT_W'(i) < count) && (entries[i] < op_value);
      eq_now[i] = (stif_pkg::CNT_W'(i) < count) && (entries[i] == op_value);
    end
  end

  // The table is sorted, so lt_mask is a run of ones from entry 0; the
  // insert slot is the first zero in that run.
  always_comb begin
    slot_hot[0] = !lt_mask[0];
    for (int i = 1; i < stif_pkg::CAPACITY; i++) begin
      slot_hot[i] = !lt_mask[i] && lt_mask[i-1];
    end
    slot_idx = '0;
    for (int i = 0; i < stif_pkg::CAPACITY; i++) begin
      if (slot_hot[i]) begin
        slot_idx = slot_idx | stif_pkg::IDX_W'(i);
      end
    end
  end

  assign found      = |(slot_hot & eq_mask);
  assign full       = (count == stif_pkg::CNT_W'(stif_pkg::CAPACITY));
  assign do_insert  = cmd.commit && (op_kind == stif_pkg::KIND_INSERT) && !full;
  assign count_next = do_insert ? count + stif_pkg::CNT_W'(1) : count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_op) begin
      op_kind  <= in_kind;
      op_value <= in_value;
    end
    if (cmd.capture) begin
      lt_mask <= lt_now;
      eq_mask <= eq_now;
    end
    // Shift the tail up one place and drop the operand into the slot.
    if (do_insert) begin
      if (slot_hot[0]) begin
        entries[0] <= op_value;
      end
      for (int i = 1; i < stif_pkg::CAPACITY; i++) begin
        if (slot_hot[i]) begin
          entries[i] <= op_value;
        end else if (!lt_mask[i]) begin
          entries[i] <= entries[i-1];
        end
      end
    end
    if (cmd.commit) begin
      res_count <= stif_pkg::POS_W'(count_next);
      if (op_kind == stif_pkg::KIND_INSERT) begin
        res_position <= '0;
        res_status   <= full ? stif_pkg::ST_FULL : stif_pkg::ST_OK;
      end else if (found) begin
        res_position <= stif_pkg::POS_W'(stif_pkg::CNT_W'(slot_idx) + stif_pkg::CNT_W'(1));
        res_status   <= stif_pkg::ST_OK;
      end else begin
        res_position <= '0;
        res_status   <= stif_pkg::ST_NOT_FOUND;
      end
    end
  end

endmodule

/* rtl/sorted_table_insert_find_unit.sv */
`timescale 1ns / 1ps

// Sorted table of up to 16 signed 32-bit values, kept in ascending order.
// Input stream: one beat per operation; tuser[0] is the kind (0 insert,
// 1 find) and tdata carries the signed value. Output stream: one beat per
// operation carrying position, status and the entry count after the op.
// An insert places the value after every smaller entry; an insert into a
// full table is dropped with status 2. A find returns the 1-based place of
// the first equal entry, or position 0 with status 1.
// The result passes the states IDLE, COMPARE and COMMIT: the accepting edge
// latches the beat, COMPARE registers the parallel compare of all entries,
// and COMMIT shifts the table and loads the result. No new beat is taken
// until the operation before it has committed. The finished result sits in
// an output register, so the next beat is accepted while it waits; a
// stalled receiver holds the operation after that in its commit step.
// Reset empties the table (count to 0) and clears the output valid; the
// entries themselves are not cleared and are never read beyond the count.

module sorted_table_insert_find_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic [0:0]  s_tuser,   // [0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [4:0] position, [6:5] status, [11:7] entry_count
);

  stif_pkg::dp_cmd_t                cmd;
  logic [stif_pkg::POS_W-1:0]       res_position;
  logic [stif_pkg::STAT_W-1:0]      res_status;
  logic [stif_pkg::POS_W-1:0]       res_count;

  stif_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd)
  );

  stif_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .in_kind      (s_tuser[0]),
    .in_value     ($signed(s_tdata)),
    .res_position (res_position),
    .res_status   (res_status),
    .res_count    (res_count)
  );

  // Pack result fields from the low bit up, pad to whole bytes.
  assign m_tdata = {4'd0, res_count, res_status, res_position};

endmodule
